FILE: rtl/atu_pkg.sv
// Package for the accelerometer tilt angle unit: widths, constants, the
// CORDIC arctangent table and small helper functions. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package atu_pkg;

	localparam int ROTATION_STAGES = 16;
	localparam int ANGLE_FRACTION_BITS = 7;
	localparam int INT_FRAC = 20;
	localparam int DW = 34;
	localparam int AW = 30;
	localparam int SW = 14;
	localparam int OPER_SHIFT = 16;
	localparam int OUT_SHIFT = INT_FRAC - ANGLE_FRACTION_BITS;
	localparam int SHW = 5;
	localparam int LAT = 2 * ROTATION_STAGES + 3;
	localparam logic signed [AW-1:0] HALF_TURN = AW'(180 * (1 << INT_FRAC));
	localparam logic signed [AW-1:0] QUARTER_TURN = AW'(90 * (1 << INT_FRAC));
	localparam logic [15:0] GAIN_INV = 16'd39797;

	typedef struct packed {
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] y;
		logic signed [AW-1:0] a;
		logic byp;
	} vec_t;

	typedef struct packed {
		logic signed [SW-1:0] x;
		logic signed [SW-1:0] y;
		logic signed [SW-1:0] z;
	} samp_t;

	function automatic logic signed [AW-1:0] atan_entry(input logic [SHW-1:0] i);
		logic signed [AW-1:0] r;
		unique case (i)
			5'd0: r = AW'(47185920);
			5'd1: r = AW'(27855475);
			5'd2: r = AW'(14718068);
			5'd3: r = AW'(7471121);
			5'd4: r = AW'(3750058);
			5'd5: r = AW'(1876857);
			5'd6: r = AW'(938658);
			5'd7: r = AW'(469357);
			5'd8: r = AW'(234682);
			5'd9: r = AW'(117342);
			5'd10: r = AW'(58671);
			5'd11: r = AW'(29335);
			5'd12: r = AW'(14668);
			5'd13: r = AW'(7334);
			5'd14: r = AW'(3667);
			5'd15: r = AW'(1833);
			5'd16: r = AW'(917);
			5'd17: r = AW'(458);
			5'd18: r = AW'(229);
			5'd19: r = AW'(115);
			5'd20: r = AW'(57);
			5'd21: r = AW'(29);
			5'd22: r = AW'(14);
			5'd23: r = AW'(7);
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [SW-1:0] sample_of(input logic [7:0] hi,
			input logic [7:0] lo);
		logic signed [16:0] t;
		t = $signed({hi[7], hi, lo}) + (hi[7] ? 17'sd3 : 17'sd0);
		return t[15:2];
	endfunction

	function automatic logic signed [DW-1:0] to_oper(input logic signed [SW-1:0] s);
		return {{(DW-SW-OPER_SHIFT){s[SW-1]}}, s, {OPER_SHIFT{1'b0}}};
	endfunction

	function automatic logic signed [AW-1:0] angle_out(input logic signed [AW-1:0] a,
			input logic signed [AW-1:0] lo, input logic signed [AW-1:0] hi);
		logic signed [AW-1:0] c;
		logic signed [AW-1:0] r;
		c = a;
		if (c < lo) begin
			c = lo;
		end
		if (c > hi) begin
			c = hi;
		end
		r = c + AW'(1 << (OUT_SHIFT - 1));
		return r >>> OUT_SHIFT;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/accel_tilt_angle_unit.sv
// Top level of the accelerometer tilt angle unit: two rows of CORDIC cells
// with a gain correction between them. Depends on atu_pkg, atu_prep, atu_cell.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
// A beat is offered by raising start with the six sensor bytes on the byte
// ports; it is taken at the clock edge where start is high and busy is low.
// busy is always low, so a new beat can be taken in every cycle.
// Each beat yields one result beat, shown for one cycle with done high:
// the three 14-bit samples, roll, pitch and tilt in 1/128 degree, and
// tilt_valid. Results come out in the order the beats were taken.
// A beat passes through an input register, a row of cells for roll and the
// X-Y magnitude, a register for the gain-corrected magnitudes, a second row
// of cells for pitch and tilt, and the output register. Throughput is one
// beat per cycle, set by the fully pipelined cell rows.
// Reset clears the pipeline valid line, so no done strobe follows reset
// until a new beat is taken. The receiver cannot stall; each result beat
// must be taken in the cycle it is shown.
module accel_tilt_angle_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic busy,
	input  wire logic [7:0] x_high_byte,
	input  wire logic [7:0] x_low_byte,
	input  wire logic [7:0] y_high_byte,
	input  wire logic [7:0] y_low_byte,
	input  wire logic [7:0] z_high_byte,
	input  wire logic [7:0] z_low_byte,
	output logic done,
	output logic signed [13:0] sample_x,
	output logic signed [13:0] sample_y,
	output logic signed [13:0] sample_z,
	output logic signed [15:0] roll_angle,
	output logic signed [14:0] pitch_angle,
	output logic [14:0] tilt_deg,
	output logic tilt_valid
);

	localparam int N = atu_pkg::ROTATION_STAGES;
	localparam int L = atu_pkg::LAT;

	logic [L-1:0] vld_q;
	atu_pkg::samp_t samp_q [0:L-2];
	atu_pkg::vec_t roll_in, rxy_in, pitch_in, tilt_in;
	atu_pkg::vec_t roll_c [0:N-1];
	atu_pkg::vec_t rxy_c [0:N-1];
	atu_pkg::vec_t pitch_c [0:N-1];
	atu_pkg::vec_t tilt_c [0:N-1];
	logic [47:0] ryz_prod, rxy_prod;
	logic signed [atu_pkg::DW-1:0] ryz_q, rxy_q;
	logic signed [atu_pkg::AW-1:0] roll_raw_q;
	logic signed [15:0] roll_dly_q [0:N-1];
	logic signed [atu_pkg::AW-1:0] roll_r, pitch_r, tilt_r;
	logic nz;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[L-2:0], start & ~busy};
		end
	end

	always_ff @(posedge clk) begin
		samp_q[0].x <= atu_pkg::sample_of(x_high_byte, x_low_byte);
		samp_q[0].y <= atu_pkg::sample_of(y_high_byte, y_low_byte);
		samp_q[0].z <= atu_pkg::sample_of(z_high_byte, z_low_byte);
		for (int k = 1; k < L - 1; k++) begin
			samp_q[k] <= samp_q[k-1];
		end
	end

	atu_prep u_prep_roll (
		.x(atu_pkg::to_oper(samp_q[0].z)),
		.y(atu_pkg::to_oper(samp_q[0].y)),
		.v(roll_in)
	);

	atu_prep u_prep_rxy (
		.x(atu_pkg::to_oper(samp_q[0].x)),
		.y(atu_pkg::to_oper(samp_q[0].y)),
		.v(rxy_in)
	);

	for (genvar j = 0; j < N; j++) begin : g_row1
		atu_cell u_roll (
			.clk(clk),
			.d(j == 0 ? roll_in : roll_c[(j == 0) ? 0 : j-1]),
			.sh(atu_pkg::SHW'(j)),
			.atan(atu_pkg::atan_entry(atu_pkg::SHW'(j))),
			.q(roll_c[j])
		);
		atu_cell u_rxy (
			.clk(clk),
			.d(j == 0 ? rxy_in : rxy_c[(j == 0) ? 0 : j-1]),
			.sh(atu_pkg::SHW'(j)),
			.atan(atu_pkg::atan_entry(atu_pkg::SHW'(j))),
			.q(rxy_c[j])
		);
	end

	// Magnitudes are nonnegative and below 2^31, so an unsigned product suffices.
	assign ryz_prod = roll_c[N-1].x[31:0] * atu_pkg::GAIN_INV + 48'd32768;
	assign rxy_prod = rxy_c[N-1].x[31:0] * atu_pkg::GAIN_INV + 48'd32768;

	always_ff @(posedge clk) begin
		ryz_q <= roll_c[N-1].byp ? roll_c[N-1].x
			: atu_pkg::DW'(ryz_prod[47:atu_pkg::OPER_SHIFT]);
		rxy_q <= rxy_c[N-1].byp ? rxy_c[N-1].x
			: atu_pkg::DW'(rxy_prod[47:atu_pkg::OPER_SHIFT]);
		roll_raw_q <= roll_c[N-1].a;
		roll_dly_q[0] <= roll_r[15:0];
		for (int k = 1; k < N; k++) begin
			roll_dly_q[k] <= roll_dly_q[k-1];
		end
	end

	assign roll_r = atu_pkg::angle_out(roll_raw_q, -atu_pkg::HALF_TURN,
		atu_pkg::HALF_TURN);

	atu_prep u_prep_pitch (
		.x(ryz_q),
		.y(atu_pkg::to_oper(samp_q[N+1].x)),
		.v(pitch_in)
	);

	atu_prep u_prep_tilt (
		.x(atu_pkg::to_oper(samp_q[N+1].z)),
		.y(rxy_q),
		.v(tilt_in)
	);

	for (genvar j = 0; j < N; j++) begin : g_row2
		atu_cell u_pitch (
			.clk(clk),
			.d(j == 0 ? pitch_in : pitch_c[(j == 0) ? 0 : j-1]),
			.sh(atu_pkg::SHW'(j)),
			.atan(atu_pkg::atan_entry(atu_pkg::SHW'(j))),
			.q(pitch_c[j])
		);
		atu_cell u_tilt (
			.clk(clk),
			.d(j == 0 ? tilt_in : tilt_c[(j == 0) ? 0 : j-1]),
			.sh(atu_pkg::SHW'(j)),
			.atan(atu_pkg::atan_entry(atu_pkg::SHW'(j))),
			.q(tilt_c[j])
		);
	end

	assign pitch_r = atu_pkg::angle_out(pitch_c[N-1].a, -atu_pkg::QUARTER_TURN,
		atu_pkg::QUARTER_TURN);
	assign tilt_r = atu_pkg::angle_out(tilt_c[N-1].a, '0, atu_pkg::HALF_TURN);
	assign nz = (samp_q[L-2].x != '0) || (samp_q[L-2].y != '0)
		|| (samp_q[L-2].z != '0);

	always_ff @(posedge clk) begin
		sample_x <= samp_q[L-2].x;
		sample_y <= samp_q[L-2].y;
		sample_z <= samp_q[L-2].z;
		roll_angle <= roll_dly_q[N-1];
		pitch_angle <= pitch_r[14:0];
		tilt_deg <= nz ? tilt_r[14:0] : 15'd0;
		tilt_valid <= nz;
	end

	assign done = vld_q[L-1];

endmodule

`default_nettype wire

FILE: rtl/atu_prep.sv
// Prepares a vector for CORDIC vectoring: folds the left half plane onto
// the right and flags vectors on the axis. Depends on atu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module atu_prep (
	input  wire logic signed [atu_pkg::DW-1:0] x,
	input  wire logic signed [atu_pkg::DW-1:0] y,
	output atu_pkg::vec_t v
);

	always_comb begin
		v.x = x;
		v.y = y;
		v.a = '0;
		if (x < 0) begin
			v.x = -x;
			v.y = -y;
			v.a = (y < 0) ? -atu_pkg::HALF_TURN : atu_pkg::HALF_TURN;
		end
		v.byp = (v.y == '0);
	end

endmodule

`default_nettype wire

FILE: rtl/atu_cell.sv
// One registered CORDIC vectoring micro-rotation; cells are chained into a row.
// Depends on atu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module atu_cell (
	input  wire logic clk,
	input  wire atu_pkg::vec_t d,
	input  wire logic [atu_pkg::SHW-1:0] sh,
	input  wire logic signed [atu_pkg::AW-1:0] atan,
	output atu_pkg::vec_t q
);

	logic signed [atu_pkg::DW-1:0] xv;
	logic signed [atu_pkg::DW-1:0] yv;
	logic signed [atu_pkg::DW-1:0] dx;
	logic signed [atu_pkg::DW-1:0] dy;
	atu_pkg::vec_t nxt;

	always_comb begin
		xv = d.x;
		yv = d.y;
		dx = yv >>> sh;
		dy = xv >>> sh;
		nxt = d;
		if (!d.byp) begin
			if (yv > 0) begin
				nxt.x = xv + dx;
				nxt.y = yv - dy;
				nxt.a = d.a + atan;
			end else begin
				nxt.x = xv - dx;
				nxt.y = yv + dy;
				nxt.a = d.a - atan;
			end
		end
	end

	always_ff @(posedge clk) begin
		q <= nxt;
	end

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for accel_tilt_angle_unit: directed and random sensor beats,
// checked against a built-in model of sample alignment and CORDIC angle math, or fixed
// values for three directed beats. Depends on atu_pkg and accel_tilt_angle_unit.
`timescale 1ns / 1ps

module tb_top;

	typedef struct {
		logic [7:0] xh, xl, yh, yl, zh, zl;
	} sensor_t;

	typedef struct {
		logic signed [13:0] sx, sy, sz;
		logic signed [15:0] roll;
		logic signed [14:0] pitch;
		logic [14:0] tilt;
		logic valid;
	} angles_t;

	typedef struct {
		sensor_t b;
		bit typed;
		angles_t e;
	} row_t;

	localparam longint HALF_DEG = longint'(180) <<< 20;
	localparam longint QUARTER_DEG = longint'(90) <<< 20;
	localparam longint CYCLE_LIMIT = 400000;
	localparam longint ATAN_TBL [24] = '{47185920, 27855475, 14718068, 7471121, 3750058,
		1876857, 938658, 469357, 234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
		917, 458, 229, 115, 57, 29, 14, 7};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [7:0] x_high_byte = '0, x_low_byte = '0, y_high_byte = '0;
	logic [7:0] y_low_byte = '0, z_high_byte = '0, z_low_byte = '0;
	logic busy, done, tilt_valid;
	logic signed [13:0] sample_x, sample_y, sample_z;
	logic signed [15:0] roll_angle;
	logic signed [14:0] pitch_angle;
	logic [14:0] tilt_deg;

	row_t offered_q[$];
	angles_t expected_angles_q[$];
	int mismatches = 0;
	int results_seen = 0;
	int beats_taken = 0;
	int idle_pct = 0;
	longint cycles = 0;

	accel_tilt_angle_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.x_high_byte(x_high_byte), .x_low_byte(x_low_byte),
		.y_high_byte(y_high_byte), .y_low_byte(y_low_byte),
		.z_high_byte(z_high_byte), .z_low_byte(z_low_byte),
		.done(done), .sample_x(sample_x), .sample_y(sample_y), .sample_z(sample_z),
		.roll_angle(roll_angle), .pitch_angle(pitch_angle), .tilt_deg(tilt_deg),
		.tilt_valid(tilt_valid)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic longint align_word(input logic [7:0] hi, input logic [7:0] lo);
		longint w;
		w = longint'({hi, lo});
		if (w >= 32768) begin
			w -= 65536;
		end
		return w / 4;
	endfunction

	function automatic void cordic_vector(input longint xi, input longint yi,
			output longint ang, output longint mag);
		longint x, y, z, dx, dy;
		x = xi;
		y = yi;
		z = 0;
		if (x == 0 && y == 0) begin
			ang = 0;
			mag = 0;
			return;
		end
		if (x < 0) begin
			z = (y < 0) ? -HALF_DEG : HALF_DEG;
			x = -x;
			y = -y;
		end
		if (y == 0) begin
			ang = z;
			mag = x;
			return;
		end
		for (int i = 0; i < atu_pkg::ROTATION_STAGES && i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx;
				y -= dy;
				z += ATAN_TBL[i];
			end else begin
				x -= dx;
				y += dy;
				z -= ATAN_TBL[i];
			end
		end
		ang = z;
		mag = (x * 39797 + 32768) >>> 16;
	endfunction

	function automatic longint scale_angle(input longint a, input longint lo,
			input longint hi);
		longint c;
		int sh;
		sh = 20 - atu_pkg::ANGLE_FRACTION_BITS;
		c = a < lo ? lo : (a > hi ? hi : a);
		return (c + (longint'(1) <<< (sh - 1))) >>> sh;
	endfunction

	function automatic angles_t predict_angles(input sensor_t b);
		angles_t r;
		longint sx, sy, sz, roll, ryz, pitch, rxy, tilt, dummy;
		sx = align_word(b.xh, b.xl);
		sy = align_word(b.yh, b.yl);
		sz = align_word(b.zh, b.zl);
		cordic_vector(sz * 65536, sy * 65536, roll, ryz);
		cordic_vector(ryz, sx * 65536, pitch, dummy);
		cordic_vector(sx * 65536, sy * 65536, dummy, rxy);
		cordic_vector(sz * 65536, rxy, tilt, dummy);
		r.sx = sx[13:0];
		r.sy = sy[13:0];
		r.sz = sz[13:0];
		r.roll = 16'(scale_angle(roll, -HALF_DEG, HALF_DEG));
		r.pitch = 15'(scale_angle(pitch, -QUARTER_DEG, QUARTER_DEG));
		r.valid = (sx != 0) || (sy != 0) || (sz != 0);
		r.tilt = r.valid ? 15'(scale_angle(tilt, 0, HALF_DEG)) : '0;
		return r;
	endfunction

	always @(posedge clk) begin
		row_t r;
		if (arst_n && start && !busy) begin
			r = offered_q.pop_front();
			beats_taken++;
			expected_angles_q.push_back(r.typed ? r.e : predict_angles(r.b));
		end
	end

	always @(posedge clk) begin
		angles_t e;
		if (arst_n && done) begin
			results_seen++;
			if (expected_angles_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("ERROR: result beat with no expectation at %0t", $realtime);
				end
			end else begin
				e = expected_angles_q.pop_front();
				if (e.sx !== sample_x || e.sy !== sample_y || e.sz !== sample_z
						|| e.roll !== roll_angle || e.pitch !== pitch_angle
						|| e.tilt !== tilt_deg || e.valid !== tilt_valid) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("ERROR: beat %0d exp s=%0d,%0d,%0d r=%0d p=%0d t=%0d v=%0d",
							results_seen, e.sx, e.sy, e.sz, e.roll, e.pitch, e.tilt, e.valid);
						$display("       got s=%0d,%0d,%0d r=%0d p=%0d t=%0d v=%0d",
							sample_x, sample_y, sample_z, roll_angle, pitch_angle,
							tilt_deg, tilt_valid);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic send_beat(input row_t r);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		x_high_byte <= r.b.xh;
		x_low_byte <= r.b.xl;
		y_high_byte <= r.b.yh;
		y_low_byte <= r.b.yl;
		z_high_byte <= r.b.zh;
		z_low_byte <= r.b.zl;
		start <= 1'b1;
		offered_q.push_back(r);
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
	endtask

	function automatic logic [15:0] random_word();
		case ($urandom_range(5))
			0: return 16'($signed($urandom_range(16)) - 8);
			1: return 16'h0000;
			2: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic row_t random_row();
		row_t r;
		logic [15:0] wx, wy, wz;
		wx = random_word();
		wy = random_word();
		wz = random_word();
		r.b = '{wx[15:8], wx[7:0], wy[15:8], wy[7:0], wz[15:8], wz[7:0]};
		r.typed = 1'b0;
		r.e = '{default: '0};
		return r;
	endfunction

	function automatic row_t direct_row(input logic [15:0] wx, input logic [15:0] wy,
			input logic [15:0] wz);
		row_t r;
		r.b = '{wx[15:8], wx[7:0], wy[15:8], wy[7:0], wz[15:8], wz[7:0]};
		r.typed = 1'b0;
		r.e = '{default: '0};
		return r;
	endfunction

	initial begin
		row_t directed[$];
		row_t r;
		int phase_idle[4];

		phase_idle = '{0, 75, 0, 35};
		r = direct_row(16'h0000, 16'h0000, 16'h0000);
		r.typed = 1'b1;
		r.e = '{14'sd0, 14'sd0, 14'sd0, 16'sd0, 15'sd0, 15'd0, 1'b0};
		directed.push_back(r);
		r = direct_row(16'h0000, 16'h0000, 16'h7FFF);
		r.typed = 1'b1;
		r.e = '{14'sd0, 14'sd0, 14'sd8191, 16'sd0, 15'sd0, 15'd0, 1'b1};
		directed.push_back(r);
		r = direct_row(16'h0000, 16'h0000, 16'h8000);
		r.typed = 1'b1;
		r.e = '{14'sd0, 14'sd0, -14'sd8192, 16'sd23040, 15'sd0, 15'd23040, 1'b1};
		directed.push_back(r);
		directed.push_back(direct_row(16'h7FFF, 16'h0000, 16'h0000));
		directed.push_back(direct_row(16'h8000, 16'h0000, 16'h0000));
		directed.push_back(direct_row(16'h0000, 16'h7FFF, 16'h0000));
		directed.push_back(direct_row(16'h0000, 16'h8000, 16'h0000));
		directed.push_back(direct_row(16'hFFFF, 16'hFFFD, 16'hFFFC));
		directed.push_back(direct_row(16'h0003, 16'h0004, 16'hFFFB));
		directed.push_back(direct_row(16'h7FFF, 16'h7FFF, 16'h7FFF));
		directed.push_back(direct_row(16'h8000, 16'h8000, 16'h8000));
		directed.push_back(direct_row(16'h8000, 16'h8000, 16'h7FFF));
		directed.push_back(direct_row(16'h7FFF, 16'h8000, 16'h8000));
		directed.push_back(direct_row(16'h0000, 16'hFFFC, 16'h8000));
		directed.push_back(direct_row(16'h0000, 16'h0004, 16'h8000));
		directed.push_back(direct_row(16'h1000, 16'h1000, 16'h0000));
		directed.push_back(direct_row(16'h0000, 16'h0000, 16'hFFFC));
		directed.push_back(direct_row(16'h0004, 16'h0000, 16'hFFFC));
		directed.push_back(direct_row(16'h5555, 16'hAAAA, 16'h00FF));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			send_beat(directed[i]);
		end
		for (int p = 0; p < 4; p++) begin
			idle_pct = phase_idle[p];
			repeat (370) send_beat(random_row());
		end
		start <= 1'b0;

		while (expected_angles_q.size() != 0 || offered_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (atu_pkg::LAT + 10) @(posedge clk);

		$display("Run covered %0d sensor beats (directed extremes, zero vectors, rounding", beats_taken);
		$display("of negative words, random vectors) under four sender idle patterns.");
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches found", mismatches);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
